### rtl/core/sss_pkg.sv
// Shared types, codes and the segment table of the seven-segment scan shifter.
`default_nettype none
package sss_pkg;

	// Request codes
	localparam logic FuncLoad = 1'b0;
	localparam logic FuncScan = 1'b1;

	// Display geometry
	localparam int DigitCount = 4;
	localparam int StoreDepth = 4;
	localparam int FrameBits  = 16;

	// Reciprocal of ten for 16-bit operands: x / 10 == (x * RecipTen) >> 19
	localparam logic [15:0] RecipTen   = 16'hCCCD;
	// Reciprocal of ten for operands below 1029: x / 10 == (x * RecipTenSm) >> 11
	localparam logic [7:0]  RecipTenSm = 8'd205;

	typedef logic [3:0] digit_t;
	typedef logic [1:0] scan_idx_t;
	typedef logic [3:0] bit_idx_t;
	typedef logic [FrameBits-1:0] frame_t;

	// Last stage of the conversion pipeline, as seen by the top level
	typedef struct packed {
		logic                          valid;
		logic                          func;
		logic [StoreDepth-1:0][3:0]    digits;
	} split_out_t;

	// Segment code for one decimal digit, active low, dp in bit 0
	function automatic logic [7:0] seg_code(input digit_t d);
		logic [7:0] code;
		unique case (d)
			4'd0:    code = 8'h03;
			4'd1:    code = 8'h9f;
			4'd2:    code = 8'h25;
			4'd3:    code = 8'h0d;
			4'd4:    code = 8'h99;
			4'd5:    code = 8'h49;
			4'd6:    code = 8'h41;
			4'd7:    code = 8'h1f;
			4'd8:    code = 8'h01;
			4'd9:    code = 8'h09;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

### rtl/core/sss_channels.sv
// Request and result channel interfaces of the seven-segment scan shifter.
`default_nettype none
interface sss_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

interface sss_result_if;
	logic       valid;
	logic       ready;
	logic       serial_bit;
	logic [3:0] bit_position;
	logic [1:0] digit_position;
	logic       last_bit;

	modport source (output valid, output serial_bit, output bit_position,
		output digit_position, output last_bit, input ready);
	modport sink   (input valid, input serial_bit, input bit_position,
		input digit_position, input last_bit, output ready);
endinterface
`default_nettype wire

### rtl/core/sss_digit_split.sv
// Three-stage pipeline that splits a 16-bit value into four decimal digits.
`default_nettype none
module sss_digit_split (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	sss_item_if.sink               item,
	output sss_pkg::split_out_t    split
);
	import sss_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        func_s1, func_s2, func_s3;
	logic [15:0] val_s1;
	logic [12:0] q1_s1, q1_s2;
	logic [9:0]  q2_s2, q2_s3;
	logic [6:0]  q3_s3;
	digit_t      d0_s2, d0_s3, d1_s3;

	logic [31:0] prod1;
	logic [28:0] prod2;
	logic [25:0] prod3;
	logic [14:0] prod4;
	logic [2:0]  q4;
	digit_t      d0_c, d1_c, d2_c, d3_c;

	// Accept a request whenever the pipeline moves
	assign item.ready = adv;

	// First quotient straight from the request
	assign prod1 = 32'(item.value) * 32'(RecipTen);
	// Units digit and second quotient
	assign d0_c  = 4'(val_s1 - 16'(16'(q1_s1) * 16'd10));
	assign prod2 = 29'(q1_s1) * 29'(RecipTen);
	// Tens digit and third quotient
	assign d1_c  = 4'(q1_s2 - 13'(13'(q2_s2) * 13'd10));
	assign prod3 = 26'(q2_s2) * 26'(RecipTen);
	// Hundreds and thousands digits; ten-thousands is dropped
	assign d2_c  = 4'(q2_s3 - 10'(10'(q3_s3) * 10'd10));
	assign prod4 = 15'(q3_s3) * 15'(RecipTenSm);
	assign q4    = prod4[13:11];
	assign d3_c  = 4'(q3_s3 - 7'(7'(q4) * 7'd10));

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= item.func;
			val_s1  <= item.value;
			q1_s1   <= prod1[31:19];
			func_s2 <= func_s1;
			d0_s2   <= d0_c;
			q1_s2   <= q1_s1;
			q2_s2   <= prod2[28:19];
			func_s3 <= func_s2;
			d0_s3   <= d0_s2;
			d1_s3   <= d1_c;
			q2_s3   <= q2_s2;
			q3_s3   <= prod3[25:19];
		end
	end

	assign split.valid  = v_s3;
	assign split.func   = func_s3;
	assign split.digits = {d3_c, d2_c, d1_s3, d0_s3};

endmodule
`default_nettype wire

### rtl/core/sss_frame_shift.sv
// Output shifter that sends one 16-bit frame as serial bits, first bit at bit 0.
`default_nettype none
module sss_frame_shift (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire sss_pkg::frame_t     frame,
	input  wire sss_pkg::scan_idx_t  digit,
	output logic                     free,
	sss_result_if.source             result
);
	import sss_pkg::*;

	logic      busy_q;
	frame_t    frame_q;
	bit_idx_t  bit_cnt_q;
	scan_idx_t digit_q;
	logic      last;
	logic      taken;

	assign last  = (bit_cnt_q == bit_idx_t'(FrameBits - 1));
	assign taken = busy_q && result.ready;
	assign free  = !busy_q || (taken && last);

	// Hold the busy flag for the length of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (taken && last) begin
			busy_q <= 1'b0;
		end
	end

	// Load a frame or shift one bit per taken result
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q   <= frame;
			bit_cnt_q <= '0;
			digit_q   <= digit;
		end else if (taken && !last) begin
			frame_q   <= frame_q >> 1;
			bit_cnt_q <= bit_cnt_q + 4'd1;
		end
	end

	assign result.valid          = busy_q;
	assign result.serial_bit     = frame_q[0];
	assign result.bit_position   = bit_cnt_q;
	assign result.digit_position = digit_q;
	assign result.last_bit       = last;

endmodule
`default_nettype wire

### rtl/core/seven_segment_scan_shifter_unit.sv
// A request passes three pipeline stages; a scan's first bit is offered once it has
// left the last stage and loaded the output shifter, and one bit follows per cycle
// while taken. Loads are taken every cycle unless a waiting scan stalls the pipeline;
// a scan holds the shifter until its last bit is taken, when the next may load.
// Reset clears the digit store to zero, the scan digit to zero and all valid flags.
`default_nettype none
module seven_segment_scan_shifter_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sss_item_if.sink      item,
	sss_result_if.source  result
);
	import sss_pkg::*;

	split_out_t split;
	logic       adv;
	logic       shift_free;
	logic       scan_go;
	logic       load_go;
	digit_t     store_q [StoreDepth];
	scan_idx_t  scan_q;
	scan_idx_t  scan_next;
	logic [2:0] scan_inc;
	frame_t     frame;
	logic [3:0] sel;

	sss_digit_split u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item),
		.split  (split)
	);

	// Stall only while a scan waits for the shifter
	assign scan_go = split.valid && (split.func == FuncScan) && shift_free;
	assign load_go = split.valid && (split.func == FuncLoad);
	assign adv     = !(split.valid && (split.func == FuncScan) && !shift_free);

	// Build the frame for the current digit
	assign sel   = 4'b0001 << scan_q;
	assign frame = {seg_code(store_q[scan_q]), sel, 4'b0000};

	// Wrap the scan digit at the display width
	assign scan_inc  = 3'(scan_q) + 3'd1;
	assign scan_next = (scan_inc >= 3'(DigitCount)) ? '0 : scan_inc[1:0];

	// Hold digits and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < StoreDepth; i++) begin
				store_q[i] <= '0;
			end
			scan_q <= '0;
		end else begin
			if (load_go) begin
				for (int i = 0; i < StoreDepth; i++) begin
					store_q[i] <= split.digits[i];
				end
			end
			if (scan_go) begin
				scan_q <= scan_next;
			end
		end
	end

	sss_frame_shift u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (scan_go),
		.frame  (frame),
		.digit  (scan_q),
		.free   (shift_free),
		.result (result)
	);

endmodule
`default_nettype wire

### rtl/core/sss_checker.sv
// Port-level checks of the scan shifter's result stream, bound to the top level.
`default_nettype none
module sss_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [3:0] bit_position,
	input wire logic [1:0] digit_position,
	input wire logic       last_bit
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// Mark the last bit exactly at position fifteen
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (last_bit == (bit_position == 4'd15)))
		else $error("last_bit out of step with bit_position");

	// Advance the bit position by one within a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last_bit |=>
		res_valid && (bit_position == 4'($past(bit_position) + 4'd1)))
		else $error("frame bits not contiguous");

	// Keep the digit fixed within a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last_bit |=> digit_position == $past(digit_position))
		else $error("digit changed inside a frame");

	// Open a frame at position zero whenever valid rises
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> bit_position == 4'd0)
		else $error("frame started past bit zero");

endmodule

bind seven_segment_scan_shifter_unit sss_checker u_sss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.bit_position   (result.bit_position),
	.digit_position (result.digit_position),
	.last_bit       (result.last_bit)
);
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the seven-segment scan shifter: directed table, then random requests.
module tb_top;
	import sss_pkg::*;

	// Receiver and sender pacing limits, idle-cycle watchdog limit
	localparam int MaxStall      = 12;
	localparam int MaxGap        = 20;
	localparam int WatchdogLimit = 600;
	localparam int DrainCycles   = 24;
	localparam int RandomCount   = 105;
	localparam int PausePoint    = 60;

	// One serial bit as it leaves the result channel
	typedef struct packed {
		logic      serial_bit;
		bit_idx_t  bit_position;
		scan_idx_t digit_position;
		logic      last_bit;
	} seg_beat_t;

	// One request; a scan row may carry its frame and digit typed in
	typedef struct packed {
		logic        func;
		logic [15:0] value;
		logic        typed;
		frame_t      frame;
		scan_idx_t   digit;
	} stim_row_t;

	// Active-low segment codes for the digits zero to nine
	localparam logic [7:0] SegPattern [10] = '{
		8'h03, 8'h9f, 8'h25, 8'h0d, 8'h99, 8'h49, 8'h41, 8'h1f, 8'h01, 8'h09
	};

	localparam int DirectedRows = 25;
	localparam stim_row_t Directed [DirectedRows] = '{
		// blank store straight after reset, all four digit selects
		'{FuncScan, 16'd0,     1'b1, 16'h0310, 2'd0},
		'{FuncScan, 16'd0,     1'b1, 16'h0320, 2'd1},
		'{FuncScan, 16'd0,     1'b1, 16'h0340, 2'd2},
		'{FuncScan, 16'd0,     1'b1, 16'h0380, 2'd3},
		// largest value: ten-thousands digit dropped, shows 5535
		'{FuncLoad, 16'hFFFF,  1'b0, 16'h0000, 2'd0},
		'{FuncScan, 16'd0,     1'b1, 16'h4910, 2'd0},
		'{FuncScan, 16'd0,     1'b1, 16'h0d20, 2'd1},
		'{FuncScan, 16'd0,     1'b1, 16'h4940, 2'd2},
		'{FuncScan, 16'd0,     1'b1, 16'h4980, 2'd3},
		'{FuncLoad, 16'd9876,  1'b0, 16'h0000, 2'd0},
		'{FuncScan, 16'd0,     1'b1, 16'h4110, 2'd0},
		'{FuncScan, 16'd0,     1'b1, 16'h1f20, 2'd1},
		'{FuncScan, 16'd0,     1'b1, 16'h0140, 2'd2},
		'{FuncScan, 16'd0,     1'b1, 16'h0980, 2'd3},
		'{FuncLoad, 16'd0,     1'b0, 16'h0000, 2'd0},
		'{FuncScan, 16'd0,     1'b1, 16'h0310, 2'd0},
		'{FuncLoad, 16'd43210, 1'b0, 16'h0000, 2'd0},
		'{FuncScan, 16'd0,     1'b0, 16'h0000, 2'd0},
		'{FuncScan, 16'd0,     1'b0, 16'h0000, 2'd0},
		'{FuncScan, 16'd0,     1'b0, 16'h0000, 2'd0},
		'{FuncLoad, 16'd1234,  1'b0, 16'h0000, 2'd0},
		'{FuncScan, 16'd0,     1'b1, 16'h9910, 2'd0},
		// back-to-back loads: the later one wins, 10000 blanks to zero
		'{FuncLoad, 16'd5,     1'b0, 16'h0000, 2'd0},
		'{FuncLoad, 16'd10000, 1'b0, 16'h0000, 2'd0},
		'{FuncScan, 16'd0,     1'b1, 16'h0320, 2'd1}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sss_item_if   item ();
	sss_result_if result ();

	seven_segment_scan_shifter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	// Predicted display state and bits still to come
	digit_t    shown_digits [StoreDepth];
	scan_idx_t scan_pos;
	seg_beat_t beats_due [$];
	int        fail_count;
	int        burst_left;
	int        idle_cycles;
	int        stall_left;
	int        stall_mode;
	int        mode_cycles;

	initial begin
		forever #4 clk = ~clk;
	end

	// Work out the serial bits caused by one accepted request
	task automatic predict_request(input stim_row_t row);
		logic [15:0] rest;
		scan_idx_t   d;
		logic [7:0]  code;
		frame_t      f;
		int          i;
		if (row.func == FuncLoad) begin
			rest = row.value;
			for (i = 0; i < StoreDepth; i++) begin
				shown_digits[i] = digit_t'(rest % 16'd10);
				rest = rest / 16'd10;
			end
		end else begin
			d = scan_pos;
			code = (shown_digits[d] < 4'd10) ? SegPattern[shown_digits[d]] : 8'h00;
			f = {code, 8'h00} | (frame_t'(1) << (4 + d));
			scan_pos = (int'(d) + 1 >= DigitCount) ? scan_idx_t'(0) : d + 2'd1;
			if (row.typed) begin
				f = row.frame;
				d = row.digit;
			end
			for (i = 0; i < FrameBits; i++)
				beats_due.push_back('{f[i], bit_idx_t'(i), d, i == FrameBits - 1});
		end
	endtask

	// Hold valid within a burst, drop it for a random gap between bursts
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item.valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MaxGap) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 10);
		end
	endtask

	// Offer one request and wait for it to be taken
	task automatic drive_request(input stim_row_t row);
		item.valid <= 1'b1;
		item.func  <= row.func;
		item.value <= row.value;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		predict_request(row);
		pace();
	endtask

	function automatic stim_row_t random_request();
		stim_row_t row;
		row = '0;
		row.func = ($urandom_range(0, 99) < 40) ? FuncLoad : FuncScan;
		case ($urandom_range(0, 7))
			0:       row.value = 16'hFFFF;
			1:       row.value = 16'h0000;
			2:       row.value = 16'($urandom_range(0, 9999));
			default: row.value = 16'($urandom);
		endcase
		return row;
	endfunction

	// Stall the receiver: quiet stretches, light and heavy stall phases
	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			stall_mode  = $urandom_range(0, 2);
			mode_cycles = $urandom_range(50, 200);
		end else begin
			mode_cycles--;
		end
		if (stall_left > 0) begin
			stall_left--;
			result.ready <= 1'b0;
		end else if (stall_mode != 0 && $urandom_range(0, 99) < 15 * stall_mode) begin
			stall_left = $urandom_range(0, (stall_mode == 2) ? MaxStall - 1 : 2);
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	// Check each delivered bit against the oldest prediction
	always @(posedge clk) begin
		seg_beat_t want;
		if (arst_n && result.valid && result.ready) begin
			if (beats_due.size() == 0) begin
				$error("unexpected result: serial_bit %0b bit_position %0d",
					result.serial_bit, result.bit_position);
				fail_count++;
			end else begin
				want = beats_due.pop_front();
				if (result.serial_bit !== want.serial_bit) begin
					$error("serial_bit: expected %0b, got %0b", want.serial_bit, result.serial_bit);
					fail_count++;
				end
				if (result.bit_position !== want.bit_position) begin
					$error("bit_position: expected %0d, got %0d",
						want.bit_position, result.bit_position);
					fail_count++;
				end
				if (result.digit_position !== want.digit_position) begin
					$error("digit_position: expected %0d, got %0d",
						want.digit_position, result.digit_position);
					fail_count++;
				end
				if (result.last_bit !== want.last_bit) begin
					$error("last_bit: expected %0b, got %0b", want.last_bit, result.last_bit);
					fail_count++;
				end
			end
		end
	end

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WatchdogLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Reset, directed table, random requests, drain
	initial begin
		int n;
		item.valid   = 1'b0;
		item.func    = FuncLoad;
		item.value   = 16'h0000;
		result.ready = 1'b0;
		for (n = 0; n < StoreDepth; n++)
			shown_digits[n] = '0;
		scan_pos    = '0;
		fail_count  = 0;
		burst_left  = 0;
		idle_cycles = 0;
		stall_left  = 0;
		stall_mode  = 0;
		mode_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DirectedRows; n++)
			drive_request(Directed[n]);

		for (n = 0; n < RandomCount; n++) begin
			drive_request(random_request());
			// hold off until every predicted bit has been delivered
			if (n == PausePoint) begin
				item.valid <= 1'b0;
				while (beats_due.size() != 0) @(posedge clk);
			end
		end

		item.valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
